// File: rtl/core/srl_pkg.sv
// Shared types and constants for the S-record line parser.
package srl_pkg;

    localparam int unsigned MAX_DATA_DEF = 64;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_S      = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [2:0]  rec_type;
        logic [31:0] address;
        logic [7:0]  data_len;
        logic        sum_match;
        logic [2:0]  error_code;
    } t_result;

endpackage

// File: rtl/core/srl_hex_dec.sv
// ASCII hex digit decoder, both letter cases.
module srl_hex_dec (
    input  logic [7:0] i_ch,
    output logic       o_is_hex,
    output logic [3:0] o_nibble
);

    always_comb begin
        o_is_hex = 1'b1;
        o_nibble = 4'd0;
        if (i_ch inside {["0":"9"]}) begin
            o_nibble = 4'(i_ch - 8'h30);
        end else if (i_ch inside {["A":"F"]}) begin
            o_nibble = 4'(i_ch - 8'h37);
        end else if (i_ch inside {["a":"f"]}) begin
            o_nibble = 4'(i_ch - 8'h57);
        end else begin
            o_is_hex = 1'b0;
        end
    end

endmodule

// File: rtl/core/srl_core.sv
// Parse state and combinational step logic for one character.
module srl_core #(
    parameter int unsigned MAX_DATA = srl_pkg::MAX_DATA_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_ch,
    input  logic             i_end_of_line,
    output srl_pkg::t_result o_res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_ADDR  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CKSUM = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;
    localparam logic [2:0] PH_SKIP  = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_type, n_type;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_pair, n_pair;
    logic [3:0]  r_high, n_high;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_len, n_len;
    logic        r_have_high, n_have_high;

    logic        is_hex;
    logic [3:0]  nibble;
    logic [7:0]  pair_byte;
    logic [2:0]  alen;
    logic [8:0]  need;
    logic [7:0]  pair_inc;
    logic [7:0]  len_calc;

    srl_hex_dec u_hex (
        .i_ch     (i_ch),
        .o_is_hex (is_hex),
        .o_nibble (nibble)
    );

    assign pair_byte = {r_high, nibble};
    assign pair_inc  = r_pair + 8'd1;
    assign need      = {6'd0, alen} + 9'd1;
    assign len_calc  = 8'({1'b0, r_count} - need);

    always_comb begin
        case (r_type)
            3'd2, 3'd6: alen = 3'd3;
            3'd3, 3'd5: alen = 3'd4;
            default:    alen = 3'd2;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_count     = r_count;
        n_pair      = r_pair;
        n_high      = r_high;
        n_addr      = r_addr;
        n_sum       = r_sum;
        n_len       = r_len;
        n_have_high = r_have_high;
        o_res       = '0;

        if (i_end_of_line) begin
            if (r_phase >= PH_TYPE && r_phase <= PH_CKSUM) begin
                o_res.valid      = 1'b1;
                o_res.kind       = srl_pkg::KIND_ERROR;
                o_res.error_code = srl_pkg::ERR_TRUNCATED;
            end
            n_phase     = PH_IDLE;
            n_have_high = 1'b0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_ch != "S") begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = srl_pkg::KIND_ERROR;
                        o_res.error_code = srl_pkg::ERR_NO_S;
                        n_phase          = PH_SKIP;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_count     = '0;
                    n_pair      = '0;
                    n_high      = '0;
                    n_addr      = '0;
                    n_sum       = '0;
                    n_len       = '0;
                    n_have_high = 1'b0;
                    n_phase     = PH_COUNT;
                    case (i_ch)
                        "0":     n_type = 3'd0;
                        "1":     n_type = 3'd1;
                        "2":     n_type = 3'd2;
                        "3":     n_type = 3'd3;
                        "5":     n_type = 3'd4;
                        "7":     n_type = 3'd5;
                        "8":     n_type = 3'd6;
                        "9":     n_type = 3'd7;
                        default: begin
                            n_count     = r_count;
                            n_pair      = r_pair;
                            n_high      = r_high;
                            n_addr      = r_addr;
                            n_sum       = r_sum;
                            n_len       = r_len;
                            n_phase     = PH_SKIP;
                            o_res.valid      = 1'b1;
                            o_res.kind       = srl_pkg::KIND_ERROR;
                            o_res.error_code = srl_pkg::ERR_BAD_TYPE;
                        end
                    endcase
                end
                PH_COUNT, PH_ADDR, PH_DATA, PH_CKSUM: begin
                    if (!is_hex) begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = srl_pkg::KIND_ERROR;
                        o_res.error_code = srl_pkg::ERR_BAD_HEX;
                        n_phase          = PH_SKIP;
                        n_have_high      = 1'b0;
                    end else if (!r_have_high) begin
                        n_high      = nibble;
                        n_have_high = 1'b1;
                    end else begin
                        n_have_high = 1'b0;
                        if (r_phase == PH_COUNT) begin
                            n_count = pair_byte;
                            n_sum   = r_sum + pair_byte;
                            n_pair  = '0;
                            n_phase = PH_ADDR;
                        end else if (r_phase == PH_ADDR) begin
                            n_addr = {r_addr[23:0], pair_byte};
                            n_sum  = r_sum + pair_byte;
                            n_pair = pair_inc;
                            if (pair_inc >= {5'd0, alen}) begin
                                if ({1'b0, r_count} < need ||
                                    len_calc > 8'(MAX_DATA)) begin
                                    o_res.valid      = 1'b1;
                                    o_res.kind       = srl_pkg::KIND_ERROR;
                                    o_res.error_code = srl_pkg::ERR_BAD_LEN;
                                    n_phase          = PH_SKIP;
                                end else begin
                                    n_len   = len_calc;
                                    n_pair  = '0;
                                    n_phase = (len_calc != 8'd0) ? PH_DATA : PH_CKSUM;
                                end
                            end
                        end else if (r_phase == PH_DATA) begin
                            o_res.valid      = 1'b1;
                            o_res.kind       = srl_pkg::KIND_DATA;
                            o_res.data_byte  = pair_byte;
                            o_res.byte_index = r_pair;
                            o_res.rec_type   = r_type;
                            o_res.address    = r_addr;
                            o_res.data_len   = r_len;
                            n_sum  = r_sum + pair_byte;
                            n_pair = pair_inc;
                            if (pair_inc >= r_len) begin
                                n_phase = PH_CKSUM;
                            end
                        end else begin
                            o_res.valid     = 1'b1;
                            o_res.kind      = srl_pkg::KIND_DONE;
                            o_res.rec_type  = r_type;
                            o_res.address   = r_addr;
                            o_res.data_len  = r_len;
                            o_res.sum_match = (~r_sum == pair_byte);
                            n_phase         = PH_DONE;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_type      <= '0;
            r_count     <= '0;
            r_pair      <= '0;
            r_high      <= '0;
            r_addr      <= '0;
            r_sum       <= '0;
            r_len       <= '0;
            r_have_high <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_count     <= n_count;
            r_pair      <= n_pair;
            r_high      <= n_high;
            r_addr      <= n_addr;
            r_sum       <= n_sum;
            r_len       <= n_len;
            r_have_high <= n_have_high;
        end
    end

endmodule

// File: rtl/core/srecord_line_parser_top.sv
// Top level of the S-record line parser: input register, parse step, result register.
// One ASCII character is taken per transaction and the block sustains one character
// per clock cycle while the result register is not stalled. A character is held in
// the input register while the combinational parse step updates the record state,
// and any result it produces is captured in the result register when the step is
// taken. Each character yields at most one result: a data byte, a record-complete
// summary with the checksum check, or an error (reported once; the rest of the line
// is then ignored until end of line). The input side stalls only while a character
// is held and the result register is full and stalled.
module srecord_line_parser_top #(
    parameter int unsigned MAX_DATA = srl_pkg::MAX_DATA_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic [2:0]  o_rec_type,
    output logic [31:0] o_address,
    output logic [7:0]  o_data_len,
    output logic        o_sum_match,
    output logic [2:0]  o_error_code
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_eol;
    logic             out_ready;
    logic             step;
    srl_pkg::t_result res;
    srl_pkg::t_result r_res;

    assign out_ready = !r_res.valid || !i_stall;
    assign step      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    srl_core #(
        .MAX_DATA (MAX_DATA)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_ch          (r_ch),
        .i_end_of_line (r_eol),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ch  <= i_ch;
            r_eol <= i_end_of_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (out_ready) begin
            r_res.valid <= res.valid;
        end
        if (out_ready && res.valid) begin
            r_res.kind       <= res.kind;
            r_res.data_byte  <= res.data_byte;
            r_res.byte_index <= res.byte_index;
            r_res.rec_type   <= res.rec_type;
            r_res.address    <= res.address;
            r_res.data_len   <= res.data_len;
            r_res.sum_match  <= res.sum_match;
            r_res.error_code <= res.error_code;
        end
    end

    assign o_valid      = r_res.valid;
    assign o_kind       = r_res.kind;
    assign o_data_byte  = r_res.data_byte;
    assign o_byte_index = r_res.byte_index;
    assign o_rec_type   = r_res.rec_type;
    assign o_address    = r_res.address;
    assign o_data_len   = r_res.data_len;
    assign o_sum_match  = r_res.sum_match;
    assign o_error_code = r_res.error_code;

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == srl_pkg::KIND_ERROR) |-> (o_error_code != srl_pkg::ERR_NONE))
        else $error("error transaction without error code");

    a_ok_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != srl_pkg::KIND_ERROR) |-> (o_error_code == srl_pkg::ERR_NONE))
        else $error("non-error transaction carries error code");

    a_index_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == srl_pkg::KIND_DATA) |-> (o_byte_index < o_data_len))
        else $error("data byte index beyond record length");

    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != srl_pkg::KIND_ERROR) |-> (o_data_len <= 8'(MAX_DATA)))
        else $error("record length above limit");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the S-record line parser: directed lines, then random lines.
module testbench;

    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_CHARS = 900;
    localparam int MAX_SHOWN = 10;
    localparam logic [7:0] CH_S = "S";
    localparam logic [7:0] TYPE_DIGITS [8] = '{"0", "1", "2", "3", "5", "7", "8", "9"};

    typedef enum logic [3:0] {
        PH_IDLE, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_CKSUM, PH_DONE, PH_SKIP
    } parse_phase_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        i_end_of_line;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_byte_index;
    logic [2:0]  o_rec_type;
    logic [31:0] o_address;
    logic [7:0]  o_data_len;
    logic        o_sum_match;
    logic [2:0]  o_error_code;

    srecord_line_parser_top dut (.*);

    // parser shadow state
    parse_phase_e ph = PH_IDLE;
    logic [2:0]   rec_type = '0;
    logic [7:0]   rec_count = '0;
    logic [7:0]   pairs = '0;
    logic [3:0]   hi_nib = '0;
    logic         have_hi = 1'b0;
    logic [31:0]  rec_addr = '0;
    logic [7:0]   rec_sum = '0;
    logic [7:0]   rec_len = '0;

    srl_pkg::t_result pending_results [$];
    logic [7:0]  line_q [$];
    int          n_fail = 0;
    int          n_chars = 0;
    int          n_lines = 0;
    int          n_bytes_seen = 0;
    int          n_records_seen = 0;
    int          n_errors_seen = 0;
    int          idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic int digit_to_type(input logic [7:0] c);
        for (int i = 0; i < 8; i++)
            if (TYPE_DIGITS[i] == c) return i;
        return -1;
    endfunction

    function automatic int addr_size(input logic [2:0] t);
        if (t == 3'd2 || t == 3'd6) return 3;
        if (t == 3'd3 || t == 3'd5) return 4;
        return 2;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit lower);
        if (nib < 10) return 8'("0") + 8'(nib);
        return (lower ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
    endfunction

    task automatic flag_error(input logic [2:0] code);
        srl_pkg::t_result r;
        r = '0;
        r.valid = 1'b1;
        r.kind = srl_pkg::KIND_ERROR;
        r.error_code = code;
        pending_results.push_back(r);
        ph = PH_SKIP;
        have_hi = 1'b0;
    endtask

    task automatic predict_char(input logic [7:0] c, input logic eol);
        srl_pkg::t_result r;
        int         v;
        int         alen;
        logic [7:0] b;
        r = '0;
        r.valid = 1'b1;
        if (eol) begin
            if (ph != PH_IDLE && ph != PH_DONE && ph != PH_SKIP)
                flag_error(srl_pkg::ERR_TRUNCATED);
            ph = PH_IDLE;
            have_hi = 1'b0;
            return;
        end
        case (ph)
            PH_IDLE: begin
                if (c != CH_S) flag_error(srl_pkg::ERR_NO_S);
                else ph = PH_TYPE;
                return;
            end
            PH_TYPE: begin
                v = digit_to_type(c);
                if (v < 0) begin
                    flag_error(srl_pkg::ERR_BAD_TYPE);
                    return;
                end
                rec_type = 3'(v);
                rec_count = '0;
                pairs = '0;
                hi_nib = '0;
                rec_addr = '0;
                rec_sum = '0;
                rec_len = '0;
                have_hi = 1'b0;
                ph = PH_COUNT;
                return;
            end
            PH_DONE, PH_SKIP: return;
            default: ;
        endcase
        v = hex_value(c);
        if (v < 0) begin
            flag_error(srl_pkg::ERR_BAD_HEX);
            return;
        end
        if (!have_hi) begin
            hi_nib = 4'(v);
            have_hi = 1'b1;
            return;
        end
        have_hi = 1'b0;
        b = {hi_nib, 4'(v)};
        r.rec_type = rec_type;
        case (ph)
            PH_COUNT: begin
                rec_count = b;
                rec_sum += b;
                pairs = '0;
                ph = PH_ADDR;
            end
            PH_ADDR: begin
                alen = addr_size(rec_type);
                rec_addr = {rec_addr[23:0], b};
                rec_sum += b;
                pairs++;
                if (int'(pairs) < alen) return;
                if (int'(rec_count) < alen + 1 ||
                    int'(rec_count) - alen - 1 > srl_pkg::MAX_DATA_DEF) begin
                    flag_error(srl_pkg::ERR_BAD_LEN);
                    return;
                end
                rec_len = rec_count - 8'(alen) - 8'd1;
                pairs = '0;
                ph = (rec_len != 0) ? PH_DATA : PH_CKSUM;
            end
            PH_DATA: begin
                r.kind = srl_pkg::KIND_DATA;
                r.data_byte = b;
                r.byte_index = pairs;
                r.address = rec_addr;
                r.data_len = rec_len;
                pending_results.push_back(r);
                rec_sum += b;
                pairs++;
                if (pairs >= rec_len) ph = PH_CKSUM;
            end
            default: begin
                r.kind = srl_pkg::KIND_DONE;
                r.address = rec_addr;
                r.data_len = rec_len;
                r.sum_match = ((8'hFF - rec_sum) == b);
                pending_results.push_back(r);
                ph = PH_DONE;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return 0;
        if (sel < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eol, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_ch = c;
        i_end_of_line = eol;
        do @(posedge i_clk); while (o_stall);
        predict_char(c, eol);
        n_chars++;
    endtask

    task automatic send_line(input bit with_eol, input bit no_gaps);
        foreach (line_q[i]) send_char(line_q[i], 1'b0, no_gaps);
        if (with_eol) send_char(8'($urandom_range(255)), 1'b1, no_gaps);
        n_lines++;
    endtask

    task automatic send_text(input string s, input bit with_eol);
        line_q.delete();
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line(with_eol, 1'b0);
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_q.push_back(hex_ascii(b[7:4], 1'($urandom_range(1))));
        line_q.push_back(hex_ascii(b[3:0], 1'($urandom_range(1))));
    endtask

    // count_override < 0 gives the correct byte count
    task automatic build_record(input logic [7:0] digit, input int n_data,
                                input logic [31:0] addr, input bit bad_sum,
                                input int count_override);
        int         alen;
        logic [7:0] cnt;
        logic [7:0] sum;
        logic [7:0] b;
        alen = addr_size(3'(digit_to_type(digit)));
        cnt = (count_override >= 0) ? 8'(count_override) : 8'(alen + n_data + 1);
        line_q.delete();
        line_q.push_back(CH_S);
        line_q.push_back(digit);
        add_byte(cnt);
        sum = cnt;
        for (int i = alen - 1; i >= 0; i--) begin
            b = addr[8*i +: 8];
            add_byte(b);
            sum += b;
        end
        for (int i = 0; i < n_data; i++) begin
            b = 8'($urandom_range(255));
            add_byte(b);
            sum += b;
        end
        b = ~sum;
        if (bad_sum) b ^= 8'($urandom_range(255, 1));
        add_byte(b);
    endtask

    task automatic test_record_types();
        foreach (TYPE_DIGITS[i]) begin
            build_record(TYPE_DIGITS[i], i, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 1'b0, -1);
            send_line(1'b1, 1'(i % 2));
        end
    endtask

    task automatic test_framing_errors();
        send_text("X", 1'b1);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_text("S4", 1'b1);
        send_text("S6", 1'b1);
        send_text("S1G0", 1'b1);
        send_text("S10Z", 1'b1);
        build_record("1", 4, 32'h1234, 1'b0, -1);
        line_q[8] = ".";
        send_line(1'b1, 1'b0);
        send_text("S", 1'b1);
        send_text("S3", 1'b1);
        send_text("S2041", 1'b1);
        build_record("2", 3, 32'hABCDEF, 1'b0, -1);
        void'(line_q.pop_back());
        send_line(1'b1, 1'b0);
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
    endtask

    task automatic test_length_limits();
        build_record("1", 0, 32'h00FF, 1'b0, 2);
        send_line(1'b1, 1'b0);
        build_record("2", 0, 32'h010203, 1'b0, 3);
        send_line(1'b1, 1'b0);
        build_record("1", 0, 32'h8000, 1'b0, -1);
        send_line(1'b1, 1'b0);
        build_record("3", srl_pkg::MAX_DATA_DEF, $urandom, 1'b0, -1);
        send_line(1'b1, 1'b1);
        build_record("1", srl_pkg::MAX_DATA_DEF + 1, $urandom, 1'b0, -1);
        send_line(1'b1, 1'b0);
        build_record("1", 2, $urandom, 1'b0, 255);
        send_line(1'b1, 1'b0);
    endtask

    task automatic test_checksum_and_trailing();
        build_record("1", 3, $urandom, 1'b1, -1);
        send_line(1'b1, 1'b0);
        build_record("9", 0, $urandom, 1'b0, -1);
        line_q.push_back("S");
        line_q.push_back("Q");
        line_q.push_back(8'h00);
        send_line(1'b1, 1'b0);
        send_text("S1ZZ1234", 1'b1);
        build_record("8", 1, $urandom, 1'b0, -1);
        send_line(1'b0, 1'b0);
        build_record("1", 2, $urandom, 1'b0, -1);
        send_line(1'b1, 1'b0);
    endtask

    task automatic test_random_lines();
        int start;
        int sel;
        int n;
        int keep;
        start = n_chars;
        while (n_chars - start < RANDOM_CHARS) begin
            sel = $urandom_range(99);
            n = $urandom_range(99);
            n = (n < 80) ? $urandom_range(16) :
                (n < 95) ? $urandom_range(63, 17) : srl_pkg::MAX_DATA_DEF;
            if (sel < 60) begin
                build_record(TYPE_DIGITS[$urandom_range(7)], n, $urandom,
                             $urandom_range(9) == 0, -1);
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(4, 1)) line_q.push_back(8'($urandom_range(255)));
                send_line($urandom_range(29) != 0, $urandom_range(3) == 0);
            end else if (sel < 70) begin
                build_record(TYPE_DIGITS[$urandom_range(7)], $urandom_range(8), $urandom,
                             1'b0, $urandom_range(255));
                send_line(1'b1, 1'b0);
            end else if (sel < 80) begin
                build_record(TYPE_DIGITS[$urandom_range(7)], $urandom_range(8), $urandom,
                             1'b0, -1);
                keep = $urandom_range(line_q.size() - 1, 1);
                while (line_q.size() > keep) void'(line_q.pop_back());
                send_line(1'b1, 1'b0);
            end else if (sel < 90) begin
                build_record(TYPE_DIGITS[$urandom_range(7)], $urandom_range(8), $urandom,
                             1'b0, -1);
                line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
                send_line(1'b1, 1'b0);
            end else begin
                line_q.delete();
                repeat ($urandom_range(8, 1)) line_q.push_back(8'($urandom_range(255)));
                send_line(1'b1, 1'b0);
            end
        end
    endtask

    // receiver back-pressure
    initial begin : rx_stall
        int sel;
        int len;
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            sel = $urandom_range(9);
            if (sel < 2) begin
                @(negedge i_clk);
                i_stall = 1'b0;
                repeat ($urandom_range(60, 20)) @(negedge i_clk);
            end else begin
                len = (sel == 9) ? $urandom_range(30, 10) : $urandom_range(3, 1);
                @(negedge i_clk);
                i_stall = 1'b1;
                repeat (len - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall = 1'b0;
                repeat ($urandom_range(5)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        srl_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            case (o_kind)
                srl_pkg::KIND_DATA: n_bytes_seen++;
                srl_pkg::KIND_DONE: n_records_seen++;
                default:            n_errors_seen++;
            endcase
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_SHOWN)
                    $display("unexpected result: kind=%0d byte=%02h idx=%0d err=%0d",
                             o_kind, o_data_byte, o_byte_index, o_error_code);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_data_byte !== want.data_byte ||
                    o_byte_index !== want.byte_index || o_rec_type !== want.rec_type ||
                    o_address !== want.address || o_data_len !== want.data_len ||
                    o_sum_match !== want.sum_match || o_error_code !== want.error_code) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN) begin
                        $display("exp k=%0d b=%02h i=%0d t=%0d a=%08h l=%0d c=%0b e=%0d",
                                 want.kind, want.data_byte, want.byte_index, want.rec_type,
                                 want.address, want.data_len, want.sum_match,
                                 want.error_code);
                        $display("got k=%0d b=%02h i=%0d t=%0d a=%08h l=%0d c=%0b e=%0d",
                                 o_kind, o_data_byte, o_byte_index, o_rec_type, o_address,
                                 o_data_len, o_sum_match, o_error_code);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch = '0;
        i_end_of_line = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_record_types();
        test_framing_errors();
        test_length_limits();
        test_checksum_and_trailing();
        test_random_lines();

        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);

        $display("covered %0d characters over %0d lines, all record types and error codes",
                 n_chars, n_lines);
        $display("seen %0d data bytes, %0d complete records, %0d error reports",
                 n_bytes_seen, n_records_seen, n_errors_seen);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
